/* design/tpr_pkg.sv */
`timescale 1ns / 1ps

package tpr_pkg;

    localparam int PHASE_BITS = 12;
    localparam int GRID_W     = 64;
    localparam int GRID_H     = 32;
    localparam int CELL_W     = 6;
    localparam int CELL_H     = 8;
    localparam int CELLS      = GRID_W * GRID_H;

    localparam int CFG_DW = 12;
    localparam int CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_MINOR  = 3'd0,
        REG_MAJOR  = 3'd1,
        REG_VIEW   = 3'd2,
        REG_SCALE  = 3'd3,
        REG_CX     = 3'd4,
        REG_CY     = 3'd5,
        REG_STEP_A = 3'd6,
        REG_STEP_B = 3'd7
    } t_cfg_reg;

    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_PLOT  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [11:0] theta_phase;
        logic [11:0] phi_phase;
    } t_item;

    typedef struct packed {
        logic [5:0] cell_x;
        logic [4:0] cell_y;
        logic [6:0] glyph;
    } t_result;

    function automatic logic [6:0] glyph_of(input logic [3:0] idx);
        logic [6:0] g;
        case (idx)
            4'd0:    g = 7'h2E;
            4'd1:    g = 7'h2C;
            4'd2:    g = 7'h2D;
            4'd3:    g = 7'h7E;
            4'd4:    g = 7'h3A;
            4'd5:    g = 7'h3B;
            4'd6:    g = 7'h3D;
            4'd7:    g = 7'h21;
            4'd8:    g = 7'h2A;
            4'd9:    g = 7'h23;
            4'd10:   g = 7'h24;
            default: g = 7'h40;
        endcase
        return g;
    endfunction

endpackage

/* design/tpr_ram.sv */
`timescale 1ns / 1ps

module tpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/torus_point_rasterizer.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                                Transfer
// item      in         start, busy, i_item                    start high and busy low
// result    out        o_result_valid, o_result               one-cycle strobe
// config    in         i_cfg_we, i_cfg_index, i_cfg_data      write enable high
//
// A plot item computes four sines, then the rotation and shading products, the
// bit-serial reciprocal, and projection and the depth test, all on one shared
// 32x32 multiplier.
// A frame item computes the angle sines and then runs a sweep that zeroes the
// depth store; the same sweep runs after reset with busy high.
// Results cannot be stalled; each appears for one cycle.

module torus_point_rasterizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tpr_pkg::t_item                i_item,
    output logic                          o_result_valid,
    output tpr_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [tpr_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [tpr_pkg::CFG_DW-1:0]    i_cfg_data
);

    import tpr_pkg::*;

    localparam int PB      = PHASE_BITS;
    localparam int ADW     = $clog2(CELLS);
    localparam int PXMAX   = (GRID_W * CELL_W > GRID_H * CELL_H) ?
                             GRID_W * CELL_W : GRID_H * CELL_H;
    localparam int PXW     = $clog2(PXMAX + 1);
    localparam int CXW     = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int CYW     = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int KX      = 24;
    localparam int RX      = (2 ** KX + CELL_W - 1) / CELL_W;
    localparam int RY      = (2 ** KX + CELL_H - 1) / CELL_H;
    localparam int DIV_TOP = 28;
    localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TRIG  = 6'b000010,
        ST_CALC  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_PROJ  = 6'b010000,
        ST_CLEAR = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_job, n_job, r_sub, n_sub;
    logic [4:0] r_step, n_step, r_dcnt, n_dcnt;
    logic [ADW-1:0] r_clr, n_clr, r_addr, n_addr;

    logic [3:0]  r_minor, r_major;
    logic [5:0]  r_view;
    logic [9:0]  r_scale;
    logic [8:0]  r_cx, r_cy;
    logic [11:0] r_inc_a, r_inc_b;
    logic [PB-1:0] r_ang_a, n_ang_a, r_ang_b, n_ang_b;

    t_item r_item, n_item;
    logic signed [15:0] r_st, n_st, r_ct, n_ct, r_sp, n_sp, r_cp, n_cp;
    logic signed [15:0] r_sa, n_sa, r_ca, n_ca, r_sb, n_sb, r_cb, n_cb;
    logic [16:0] r_xq, n_xq, r_x2, n_x2;
    logic signed [18:0] r_circ, n_circ, r_x, n_x, r_y, n_y;
    logic signed [17:0] r_z, n_z;
    logic signed [15:0] r_nx, n_nx, r_ny, n_ny;
    logic signed [35:0] r_acc, n_acc;
    logic signed [19:0] r_ya, n_ya, r_za, n_za;
    logic signed [20:0] r_xb, n_xb, r_yb, n_yb;
    logic signed [16:0] r_nya, n_nya, r_nza, n_nza;
    logic signed [17:0] r_nyb, n_nyb;
    logic [3:0]  r_idx, n_idx;
    logic [18:0] r_w, n_w, r_rem, n_rem;
    logic [28:0] r_inv, n_inv;
    logic [PXW-1:0] r_px, n_px;
    logic r_drop, n_drop;
    logic [CXW-1:0] r_ax, n_ax;
    logic r_out_valid, n_out_valid;
    t_result r_out, n_out;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] r_prod;

    logic ram_we;
    logic [ADW-1:0] ram_waddr, ram_raddr;
    logic [15:0] ram_wdata, ram_rdata;

    logic [PB-1:0] trig_base, trig_ph;
    logic [1:0]  trig_quad;
    logic [16:0] trig_x0, trig_x;
    logic [17:0] trig_t, trig_v0;
    logic signed [15:0] trig_v;

    logic signed [18:0] shade_b;
    logic [22:0] shade_m;
    logic signed [20:0] w_full;
    logic [19:0] rem_sh;
    logic signed [63:0] pix_s;
    logic signed [63:0] pix_q;
    logic pix_bad;
    logic [CYW-1:0] ay;
    logic [15:0] depth;

    tpr_ram #(.WIDTH(16), .DEPTH(CELLS)) u_depth (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (r_job[2:1])
            2'd0:    trig_base = PB'(r_item.theta_phase);
            2'd1:    trig_base = PB'(r_item.phi_phase);
            2'd2:    trig_base = r_ang_a;
            default: trig_base = r_ang_b;
        endcase
        trig_ph   = trig_base + (r_job[0] ? QUARTER : '0);
        trig_quad = trig_ph[PB-1:PB-2];
        trig_x0   = 17'(trig_ph[PB-3:0]) << (18 - PB);
        trig_x    = trig_quad[0] ? (17'd65536 - trig_x0) : trig_x0;
        trig_t    = 18'(r_prod >>> 16);
        trig_v0   = (trig_t + 18'd2) >> 2;
        if (trig_v0 > 18'd16384) begin
            trig_v = 16'sd16384;
        end else begin
            trig_v = $signed(16'(trig_v0));
        end
        if (trig_quad[1]) begin
            trig_v = -trig_v;
        end
    end

    always_comb begin
        shade_b = 19'(r_prod >>> 14);
        shade_m = (shade_b < 0) ? '0 : ((23'(shade_b) * 23'd11) >> 14);
        w_full  = 21'(r_za) + $signed(21'({r_view, 12'd0}));
        rem_sh  = {r_rem, (r_dcnt == 5'(DIV_TOP))};
        if (r_step == 5'd2) begin
            pix_s = $signed(64'({r_cx, 28'd0})) + r_prod;
        end else begin
            pix_s = $signed(64'({r_cy, 28'd0})) - r_prod;
        end
        pix_q = (pix_s < 0) ? '0 : (pix_s >>> 28);
        if (r_step == 5'd2) begin
            pix_bad = (pix_s <= -(64'sd1 <<< 28)) || (pix_q >= 64'(GRID_W * CELL_W));
        end else begin
            pix_bad = (pix_s <= -(64'sd1 <<< 28)) || (pix_q >= 64'(GRID_H * CELL_H));
        end
        ay    = CYW'(r_prod >> KX);
        depth = (r_inv > 29'd65535) ? 16'hFFFF : 16'(r_inv);
    end

    always_comb begin
        n_state = r_state;  n_job = r_job;  n_sub = r_sub;  n_step = r_step;
        n_dcnt = r_dcnt;  n_clr = r_clr;  n_addr = r_addr;
        n_ang_a = r_ang_a;  n_ang_b = r_ang_b;  n_item = r_item;
        n_st = r_st;  n_ct = r_ct;  n_sp = r_sp;  n_cp = r_cp;
        n_sa = r_sa;  n_ca = r_ca;  n_sb = r_sb;  n_cb = r_cb;
        n_xq = r_xq;  n_x2 = r_x2;  n_circ = r_circ;  n_x = r_x;  n_y = r_y;
        n_z = r_z;  n_nx = r_nx;  n_ny = r_ny;  n_acc = r_acc;
        n_ya = r_ya;  n_za = r_za;  n_xb = r_xb;  n_yb = r_yb;
        n_nya = r_nya;  n_nza = r_nza;  n_nyb = r_nyb;  n_idx = r_idx;
        n_w = r_w;  n_rem = r_rem;  n_inv = r_inv;  n_px = r_px;  n_drop = r_drop;
        n_ax = r_ax;  n_out = r_out;  n_out_valid = 1'b0;
        mul_a = '0;  mul_b = '0;
        ram_we = 1'b0;  ram_waddr = r_clr;  ram_wdata = '0;  ram_raddr = r_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_sub  = '0;
                    n_state = ST_TRIG;
                    if (i_item.func == FUNC_PLOT) begin
                        n_job = 3'd0;
                    end else begin
                        n_job   = 3'd4;
                        n_clr   = '0;
                        n_ang_a = r_ang_a + PB'(r_inc_a);
                        n_ang_b = r_ang_b + PB'(r_inc_b);
                    end
                end
            end
            ST_TRIG: begin
                n_sub = r_sub + 3'd1;
                case (r_sub)
                    3'd0: begin
                        n_xq  = trig_x;
                        mul_a = $signed(32'(trig_x));
                        mul_b = $signed(32'(trig_x));
                    end
                    3'd1: begin
                        n_x2  = 17'(trig_t);
                        mul_a = 32'sd5223;
                        mul_b = $signed(32'(trig_t));
                    end
                    3'd2: begin
                        mul_a = $signed(32'(18'd42334 - trig_t));
                        mul_b = $signed(32'(r_x2));
                    end
                    3'd3: begin
                        mul_a = $signed(32'(18'd102944 - trig_t));
                        mul_b = $signed(32'(r_xq));
                    end
                    default: begin
                        case (r_job)
                            3'd0:    n_st = trig_v;
                            3'd1:    n_ct = trig_v;
                            3'd2:    n_sp = trig_v;
                            3'd3:    n_cp = trig_v;
                            3'd4:    n_sa = trig_v;
                            3'd5:    n_ca = trig_v;
                            3'd6:    n_sb = trig_v;
                            default: n_cb = trig_v;
                        endcase
                        n_sub = '0;
                        n_job = r_job + 3'd1;
                        if (r_job == 3'd3) begin
                            n_state = ST_CALC;
                            n_step  = '0;
                        end else if (r_job == 3'd7) begin
                            n_state = ST_CLEAR;
                        end
                    end
                endcase
            end
            ST_CALC: begin
                n_step = r_step + 5'd1;
                case (r_step)
                    5'd0: begin
                        mul_a = $signed(32'(r_minor));  mul_b = 32'(r_ct);
                    end
                    5'd1: begin
                        n_circ = $signed(19'({r_major, 12'd0})) + 19'(r_prod >>> 2);
                        mul_a = $signed(32'(r_minor));  mul_b = 32'(r_st);
                    end
                    5'd2: begin
                        n_z = 18'(r_prod >>> 2);
                        mul_a = 32'(r_circ);  mul_b = 32'(r_cp);
                    end
                    5'd3: begin
                        n_x = 19'(r_prod >>> 14);
                        mul_a = 32'(r_circ);  mul_b = 32'(r_sp);
                    end
                    5'd4: begin
                        n_y = 19'(r_prod >>> 14);
                        mul_a = 32'(r_ct);  mul_b = 32'(r_cp);
                    end
                    5'd5: begin
                        n_nx = 16'(r_prod >>> 14);
                        mul_a = 32'(r_ct);  mul_b = 32'(r_sp);
                    end
                    5'd6: begin
                        n_ny = 16'(r_prod >>> 14);
                        mul_a = 32'(r_y);  mul_b = 32'(r_ca);
                    end
                    5'd7: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_z);  mul_b = 32'(r_sa);
                    end
                    5'd8: begin
                        n_ya = 20'((r_acc - 36'(r_prod)) >>> 14);
                        mul_a = 32'(r_y);  mul_b = 32'(r_sa);
                    end
                    5'd9: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_z);  mul_b = 32'(r_ca);
                    end
                    5'd10: begin
                        n_za = 20'((r_acc + 36'(r_prod)) >>> 14);
                        mul_a = 32'(r_x);  mul_b = 32'(r_cb);
                    end
                    5'd11: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_ya);  mul_b = 32'(r_sb);
                    end
                    5'd12: begin
                        n_xb = 21'((r_acc - 36'(r_prod)) >>> 14);
                        mul_a = 32'(r_x);  mul_b = 32'(r_sb);
                    end
                    5'd13: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_ya);  mul_b = 32'(r_cb);
                    end
                    5'd14: begin
                        n_yb = 21'((r_acc + 36'(r_prod)) >>> 14);
                        mul_a = 32'(r_ny);  mul_b = 32'(r_ca);
                    end
                    5'd15: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_st);  mul_b = 32'(r_sa);
                    end
                    5'd16: begin
                        n_nya = 17'((r_acc - 36'(r_prod)) >>> 14);
                        mul_a = 32'(r_ny);  mul_b = 32'(r_sa);
                    end
                    5'd17: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_st);  mul_b = 32'(r_ca);
                    end
                    5'd18: begin
                        n_nza = 17'((r_acc + 36'(r_prod)) >>> 14);
                        mul_a = 32'(r_nx);  mul_b = 32'(r_sb);
                    end
                    5'd19: begin
                        n_acc = 36'(r_prod);
                        mul_a = 32'(r_nya);  mul_b = 32'(r_cb);
                    end
                    5'd20: begin
                        n_nyb = 18'((r_acc + 36'(r_prod)) >>> 14);
                    end
                    5'd21: begin
                        mul_a = 32'(r_nyb) - 32'(r_nza);
                        mul_b = 32'sd11585;
                    end
                    default: begin
                        n_idx = (shade_m > 23'd11) ? 4'd11 : 4'(shade_m);
                        if (w_full <= 0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_w     = 19'(w_full);
                            n_rem   = '0;
                            n_inv   = '0;
                            n_dcnt  = 5'(DIV_TOP);
                            n_state = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_w}) begin
                    n_rem = 19'(rem_sh - {1'b0, r_w});
                    n_inv = {r_inv[27:0], 1'b1};
                end else begin
                    n_rem = 19'(rem_sh);
                    n_inv = {r_inv[27:0], 1'b0};
                end
                n_dcnt = r_dcnt - 5'd1;
                if (r_dcnt == '0) begin
                    n_state = ST_PROJ;
                    n_step  = '0;
                end
            end
            ST_PROJ: begin
                n_step = r_step + 5'd1;
                case (r_step)
                    5'd0: begin
                        mul_a = $signed(32'(r_scale));  mul_b = 32'(r_xb);
                    end
                    5'd1: begin
                        mul_a = 32'(r_prod);  mul_b = $signed(32'(r_inv));
                    end
                    5'd2: begin
                        n_px   = PXW'(pix_q);
                        n_drop = pix_bad;
                        mul_a = $signed(32'(r_scale));  mul_b = 32'(r_yb);
                    end
                    5'd3: begin
                        mul_a = 32'(r_prod);  mul_b = $signed(32'(r_inv));
                    end
                    5'd4: begin
                        n_px  = PXW'(pix_q);
                        mul_a = $signed(32'(r_px));  mul_b = 32'(RX);
                        if (r_drop || pix_bad) begin
                            n_state = ST_IDLE;
                        end
                    end
                    5'd5: begin
                        n_ax  = CXW'(r_prod >> KX);
                        mul_a = $signed(32'(r_px));  mul_b = 32'(RY);
                    end
                    5'd6: begin
                        n_addr    = ADW'(32'(ay) * GRID_W + 32'(r_ax));
                        ram_raddr = n_addr;
                        n_out.cell_x = 6'(r_ax);
                        n_out.cell_y = 5'(ay);
                        n_out.glyph  = glyph_of(r_idx);
                    end
                    default: begin
                        n_state = ST_IDLE;
                        if (depth > ram_rdata) begin
                            ram_we      = 1'b1;
                            ram_waddr   = r_addr;
                            ram_wdata   = depth;
                            n_out_valid = 1'b1;
                        end
                    end
                endcase
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + ADW'(1);
                if (r_clr == ADW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_job       <= '0;
            r_sub       <= '0;
            r_step      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_ang_a     <= '0;
            r_ang_b     <= '0;
            r_sa        <= '0;
            r_ca        <= 16'sd16384;
            r_sb        <= '0;
            r_cb        <= 16'sd16384;
            r_minor     <= 4'd1;
            r_major     <= 4'd2;
            r_view      <= 6'd6;
            r_scale     <= 10'd200;
            r_cx        <= 9'd150;
            r_cy        <= 9'd135;
            r_inc_a     <= 12'd65;
            r_inc_b     <= 12'd65;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_job       <= n_job;
            r_sub       <= n_sub;
            r_step      <= n_step;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
            r_ang_a     <= n_ang_a;
            r_ang_b     <= n_ang_b;
            r_sa        <= n_sa;
            r_ca        <= n_ca;
            r_sb        <= n_sb;
            r_cb        <= n_cb;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_MINOR:  r_minor <= i_cfg_data[3:0];
                    REG_MAJOR:  r_major <= i_cfg_data[3:0];
                    REG_VIEW:   r_view  <= i_cfg_data[5:0];
                    REG_SCALE:  r_scale <= i_cfg_data[9:0];
                    REG_CX:     r_cx    <= i_cfg_data[8:0];
                    REG_CY:     r_cy    <= i_cfg_data[8:0];
                    REG_STEP_A: r_inc_a <= i_cfg_data[11:0];
                    REG_STEP_B: r_inc_b <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_item <= n_item;  r_addr <= n_addr;
        r_st <= n_st;  r_ct <= n_ct;  r_sp <= n_sp;  r_cp <= n_cp;
        r_xq <= n_xq;  r_x2 <= n_x2;  r_circ <= n_circ;  r_x <= n_x;  r_y <= n_y;
        r_z <= n_z;  r_nx <= n_nx;  r_ny <= n_ny;  r_acc <= n_acc;
        r_ya <= n_ya;  r_za <= n_za;  r_xb <= n_xb;  r_yb <= n_yb;
        r_nya <= n_nya;  r_nza <= n_nza;  r_nyb <= n_nyb;  r_idx <= n_idx;
        r_w <= n_w;  r_rem <= n_rem;  r_inv <= n_inv;  r_px <= n_px;
        r_drop <= n_drop;  r_ax <= n_ax;  r_out <= n_out;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe lasted more than one cycle");

    a_result_from_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == ST_PROJ) && !busy)
        else $error("result without a depth test");
`endif

endmodule

/* tb/torus_point_rasterizer_checker.sv */
`timescale 1ns / 1ps

module torus_point_rasterizer_checker
    import tpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  t_item             i_item,
    input  logic              o_result_valid,
    input  t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    localparam string SHADES = ".,-~:;=!*#$@";

    logic [3:0]  minor_r, major_r;
    logic [5:0]  view_d;
    logic [9:0]  scale;
    logic [8:0]  cen_x, cen_y;
    logic [11:0] step_a, step_b, ang_a, ang_b;
    logic [15:0] zbuf [CELLS];
    t_result     draws_due [$];

    assign o_pending = draws_due.size();

    function automatic longint qsine(input logic [11:0] p);
        longint x, x2, t, v;
        x = longint'(p[9:0]) << 6;
        if (p[10]) begin
            x = 65536 - x;
        end
        x2 = (x * x) >>> 16;
        t = (5223 * x2) >>> 16;
        t = ((42334 - t) * x2) >>> 16;
        t = ((102944 - t) * x) >>> 16;
        v = (t + 2) >>> 2;
        if (v > 16384) begin
            v = 16384;
        end
        return p[11] ? -v : v;
    endfunction

    function automatic longint pixel_of(input longint s);
        if (s <= -(longint'(1) << 28)) begin
            return -1;
        end
        return (s >= 0) ? (s >>> 28) : 0;
    endfunction

    task automatic predict_plot(input t_item it);
        longint st, ct, sp, cp, sa, ca, sb, cb;
        longint circ, x, y, z, ya, za, xb, yb;
        longint nx, ny, nz, nya, nza, nyb;
        longint b, idx, w, inv, dep, px, py, ax, ay;
        byte ch;
        t_result r;
        st = qsine(it.theta_phase);
        ct = qsine(it.theta_phase + 12'd1024);
        sp = qsine(it.phi_phase);
        cp = qsine(it.phi_phase + 12'd1024);
        sa = qsine(ang_a);
        ca = qsine(ang_a + 12'd1024);
        sb = qsine(ang_b);
        cb = qsine(ang_b + 12'd1024);
        circ = (longint'(major_r) << 12) + ((longint'(minor_r) * ct) >>> 2);
        x = (circ * cp) >>> 14;
        y = (circ * sp) >>> 14;
        z = (longint'(minor_r) * st) >>> 2;
        nx = (ct * cp) >>> 14;
        ny = (ct * sp) >>> 14;
        nz = st;
        ya = (y * ca - z * sa) >>> 14;
        za = (y * sa + z * ca) >>> 14;
        xb = (x * cb - ya * sb) >>> 14;
        yb = (x * sb + ya * cb) >>> 14;
        nya = (ny * ca - nz * sa) >>> 14;
        nza = (ny * sa + nz * ca) >>> 14;
        nyb = (nx * sb + nya * cb) >>> 14;
        b = ((nyb - nza) * 11585) >>> 14;
        if (b < 0) begin
            b = 0;
        end
        idx = (b * 11) >>> 14;
        if (idx > 11) begin
            idx = 11;
        end
        w = za + (longint'(view_d) << 12);
        if (w <= 0) begin
            return;
        end
        inv = (longint'(1) << 28) / w;
        dep = (inv > 65535) ? 65535 : inv;
        px = pixel_of((longint'(cen_x) << 28) + longint'(scale) * xb * inv);
        py = pixel_of((longint'(cen_y) << 28) - longint'(scale) * yb * inv);
        if (px < 0 || py < 0) begin
            return;
        end
        ax = px / CELL_W;
        ay = py / CELL_H;
        if (ax >= GRID_W || ay >= GRID_H) begin
            return;
        end
        if (dep <= longint'(zbuf[ay * GRID_W + ax])) begin
            return;
        end
        zbuf[ay * GRID_W + ax] = dep[15:0];
        ch = SHADES[idx];
        r.cell_x = ax[5:0];
        r.cell_y = ay[4:0];
        r.glyph  = ch[6:0];
        draws_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            minor_r = 1;
            major_r = 2;
            view_d  = 6;
            scale   = 200;
            cen_x   = 150;
            cen_y   = 135;
            step_a  = 65;
            step_b  = 65;
            ang_a   = 0;
            ang_b   = 0;
            foreach (zbuf[i]) zbuf[i] = 0;
            draws_due.delete();
            o_errors = 0;
        end else begin
            if (o_result_valid) begin
                if (draws_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected draw x=%0d y=%0d glyph=%h", o_result.cell_x,
                                 o_result.cell_y, o_result.glyph);
                    end
                end else begin
                    e = draws_due.pop_front();
                    if (e !== o_result) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("draw mismatch: expected x=%0d y=%0d glyph=%h,",
                                     e.cell_x, e.cell_y, e.glyph,
                                     " got x=%0d y=%0d glyph=%h",
                                     o_result.cell_x, o_result.cell_y, o_result.glyph);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MINOR:  minor_r = i_cfg_data[3:0];
                    REG_MAJOR:  major_r = i_cfg_data[3:0];
                    REG_VIEW:   view_d  = i_cfg_data[5:0];
                    REG_SCALE:  scale   = i_cfg_data[9:0];
                    REG_CX:     cen_x   = i_cfg_data[8:0];
                    REG_CY:     cen_y   = i_cfg_data[8:0];
                    REG_STEP_A: step_a  = i_cfg_data[11:0];
                    REG_STEP_B: step_b  = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (i_item.func == FUNC_FRAME) begin
                    ang_a = ang_a + step_a;
                    ang_b = ang_b + step_b;
                    foreach (zbuf[i]) zbuf[i] = 0;
                end else begin
                    predict_plot(i_item);
                end
            end
        end
    end

endmodule

/* tb/torus_point_rasterizer_tb.sv */
`timescale 1ns / 1ps

module torus_point_rasterizer_tb;
    import tpr_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              o_result_valid;
    t_result           o_result;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;
    int                errors;
    int                pending;
    t_item             last_plot;

    torus_point_rasterizer dut (.*);

    torus_point_rasterizer_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_valid, .o_result,
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic send(input logic f, input logic [11:0] th, input logic [11:0] ph);
        int gap;
        gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item.func <= f;
        i_item.theta_phase <= th;
        i_item.phi_phase <= ph;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        if (f == FUNC_PLOT) begin
            last_plot.theta_phase = th;
            last_plot.phi_phase = ph;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (busy || pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DW-1:0];
        @(posedge i_clk);
    endtask

    task automatic cfg_all(input int mi, input int ma, input int vd, input int sc,
                           input int cx, input int cy, input int sa, input int sb);
        cfg_write(REG_MINOR, mi);
        cfg_write(REG_MAJOR, ma);
        cfg_write(REG_VIEW, vd);
        cfg_write(REG_SCALE, sc);
        cfg_write(REG_CX, cx);
        cfg_write(REG_CY, cy);
        cfg_write(REG_STEP_A, sa);
        cfg_write(REG_STEP_B, sb);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        last_plot = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(FUNC_PLOT, 12'd0, 12'd0);
        send(FUNC_PLOT, 12'd0, 12'd0);
        send(FUNC_PLOT, 12'hFFF, 12'hFFF);
        send(FUNC_PLOT, 12'd1024, 12'd2048);
        send(FUNC_PLOT, 12'd2048, 12'd3072);
        send(FUNC_PLOT, 12'd3072, 12'd1024);
        send(FUNC_PLOT, 12'd1023, 12'd2047);
        send(FUNC_PLOT, 12'hAAA, 12'h555);
        send(FUNC_PLOT, 12'h555, 12'hAAA);
        send(FUNC_FRAME, 12'hFFF, 12'hFFF);
        send(FUNC_PLOT, 12'd0, 12'd0);
        send(FUNC_PLOT, 12'd512, 12'd512);
        send(FUNC_FRAME, 12'd0, 12'd0);
        send(FUNC_PLOT, 12'd3584, 12'd1536);

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            case (ph)
                0: cfg_all(15, 15, 63, 1023, 511, 511, 4095, 4095);
                1: cfg_all(1, 1, 1, 0, 0, 0, 0, 0);
                2: cfg_all(15, 15, 1, 300, 150, 135, 4095, 0);
                3: cfg_all(3, 6, 30, 800, 0, 0, 1000, 2000);
                4: cfg_all(1, 2, 6, 200, 150, 135, 65, 65);
                default: cfg_all($urandom_range(1, 15), $urandom_range(1, 15),
                                 $urandom_range(1, 63), $urandom_range(50, 1023),
                                 $urandom_range(40, 330), $urandom_range(30, 230),
                                 $urandom_range(0, 4095), $urandom_range(0, 4095));
            endcase
            send(FUNC_FRAME, 12'($urandom), 12'($urandom));
            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    send(FUNC_FRAME, 12'($urandom), 12'($urandom));
                end else if ($urandom_range(0, 9) == 0) begin
                    send(FUNC_PLOT, last_plot.theta_phase, last_plot.phi_phase);
                end else begin
                    send(FUNC_PLOT, 12'($urandom), 12'($urandom));
                end
            end
        end
        wait_idle();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
design/tpr_pkg.sv
design/tpr_ram.sv
design/torus_point_rasterizer.sv
tb/torus_point_rasterizer_checker.sv
tb/torus_point_rasterizer_tb.sv
